[hdl/tlue_pkg.sv]
// ----------------------------------------------------------------------------
// tlue_pkg
// shared types and constants for the taint label union engine
// ----------------------------------------------------------------------------
package tlue_pkg;

  localparam int LBL_W      = 8;
  localparam int MEMO_AW    = 2 * LBL_W;
  localparam int MEMO_DEPTH = 1 << MEMO_AW;

  localparam logic OP_CREATE  = 1'b0;
  localparam logic OP_COMBINE = 1'b1;

  typedef logic [LBL_W-1:0]   lbl_t;
  typedef logic [MEMO_AW-1:0] memo_addr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic       rd_en;
    memo_addr_t rd_addr;
    logic       wr_en;
    memo_addr_t wr_addr;
    lbl_t       wr_data;
  } memo_req_t;

  typedef struct packed {
    logic rd_en;
    lbl_t rd_addr;
    logic wr_en;
    lbl_t wr_addr;
    lbl_t wr_lo;
    lbl_t wr_hi;
  } par_req_t;

endpackage

[hdl/tlue_memo.sv]
// ----------------------------------------------------------------------------
// tlue_memo
// pair memo memory with a zeroing sweep after reset
// ----------------------------------------------------------------------------
module tlue_memo
  import tlue_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  memo_req_t req,
  output lbl_t      rd_data,
  output logic      busy
);

  lbl_t       mem [MEMO_DEPTH];
  lbl_t       rd_data_r;
  memo_addr_t clr_cnt_r;
  logic       clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

[hdl/tlue_parent.sv]
// ----------------------------------------------------------------------------
// tlue_parent
// parent pair memory, one entry per label
// ----------------------------------------------------------------------------
module tlue_parent
  import tlue_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic     clk,
  input  par_req_t req,
  output lbl_t     rd_lo,
  output lbl_t     rd_hi
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [2*LBL_W-1:0] mem [DEPTH];
  logic [2*LBL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= {req.wr_hi, req.wr_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  assign rd_lo = rd_data_r[LBL_W-1:0];
  assign rd_hi = rd_data_r[2*LBL_W-1:LBL_W];

endmodule

[hdl/taint_label_union_engine.sv]
// ----------------------------------------------------------------------------
// taint_label_union_engine
// creates base labels and combines label pairs through a memo memory
// ----------------------------------------------------------------------------
// On accepting a request the engine reads the pair memo and the parent
// entry of the higher label from their memories; in ST_EXEC it decides the
// answer and writes the memo, the new label's parents and the label counter
// back. A finished result sits in an output register, so the next request is
// taken while it waits; the update cycle stalls only if the previous result
// has not been taken by then. After reset the memo memory is zeroed one entry
// per cycle, and in_ready stays low until that sweep is done.
// Labels are never handed out at or beyond the reserved label
// min(LABEL_COUNT-1, 255); such an allocation returns label 0 with
// out_of_labels set.
module taint_label_union_engine
  import tlue_pkg::*;
#(
  parameter int LABEL_COUNT = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  lbl_t in_label_a,
  input  lbl_t in_label_b,
  output logic out_valid,
  input  logic out_ready,
  output lbl_t out_label,
  output logic out_out_of_labels
);

  localparam int PARENT_DEPTH = (LABEL_COUNT > 256) ? 256 : LABEL_COUNT;
  localparam logic [LBL_W:0] RESERVED_LBL =
    (LBL_W + 1)'((LABEL_COUNT > 256) ? 255 : LABEL_COUNT - 1);

  state_t    state_r, state_nxt;
  logic      op_r;
  lbl_t      a_r, b_r, lo_r, hi_r;
  lbl_t      last_allocated_r, last_allocated_nxt;
  logic      out_valid_r, out_valid_nxt;
  lbl_t      out_label_r;
  logic      out_oor_r;

  memo_req_t memo_req;
  par_req_t  par_req;
  lbl_t      memo_rd;
  lbl_t      par_rd_lo, par_rd_hi;
  logic      memo_busy;

  logic      accept, exec_fire;
  lbl_t      in_lo, in_hi;
  logic      [LBL_W:0] next_lbl;
  logic      alloc_ok, alloc;
  logic      memo_wr;
  lbl_t      res, new_lo, new_hi;
  logic      oor;

  assign in_ready  = (state_r == ST_IDLE) && !memo_busy;
  assign accept    = in_valid && in_ready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign in_lo = (in_label_a < in_label_b) ? in_label_a : in_label_b;
  assign in_hi = (in_label_a < in_label_b) ? in_label_b : in_label_a;

  assign next_lbl = {1'b0, last_allocated_r} + 1'b1;
  assign alloc_ok = next_lbl < RESERVED_LBL;

  // decide the answer from the memory read data
  always_comb begin
    res     = '0;
    oor     = 1'b0;
    alloc   = 1'b0;
    memo_wr = 1'b0;
    new_lo  = '0;
    new_hi  = '0;
    if (op_r == OP_CREATE) begin
      alloc = 1'b1;
    end else if (a_r == b_r) begin
      res = a_r;
    end else if (a_r == '0) begin
      res = b_r;
    end else if (b_r == '0) begin
      res = a_r;
    end else if (memo_rd != '0) begin
      res = memo_rd;
    end else if (par_rd_lo == lo_r || par_rd_hi == lo_r) begin
      res     = hi_r;
      memo_wr = 1'b1;
    end else begin
      alloc   = 1'b1;
      new_lo  = lo_r;
      new_hi  = hi_r;
      memo_wr = alloc_ok;
    end
    if (alloc) begin
      if (alloc_ok) begin
        res = next_lbl[LBL_W-1:0];
      end else begin
        res = '0;
        oor = 1'b1;
      end
    end
  end

  always_comb begin
    memo_req.rd_en   = accept;
    memo_req.rd_addr = {in_lo, in_hi};
    memo_req.wr_en   = exec_fire && memo_wr;
    memo_req.wr_addr = {lo_r, hi_r};
    memo_req.wr_data = res;

    par_req.rd_en   = accept;
    par_req.rd_addr = in_hi;
    par_req.wr_en   = exec_fire && alloc && alloc_ok;
    par_req.wr_addr = next_lbl[LBL_W-1:0];
    par_req.wr_lo   = new_lo;
    par_req.wr_hi   = new_hi;
  end

  tlue_memo u_memo (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (memo_req),
    .rd_data (memo_rd),
    .busy    (memo_busy)
  );

  tlue_parent #(
    .DEPTH (PARENT_DEPTH)
  ) u_parent (
    .clk   (clk),
    .req   (par_req),
    .rd_lo (par_rd_lo),
    .rd_hi (par_rd_hi)
  );

  always_comb begin
    state_nxt          = state_r;
    last_allocated_nxt = last_allocated_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (alloc && alloc_ok) begin
            last_allocated_nxt = next_lbl[LBL_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      last_allocated_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      last_allocated_r <= last_allocated_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      a_r  <= in_label_a;
      b_r  <= in_label_b;
      lo_r <= in_lo;
      hi_r <= in_hi;
    end
    if (exec_fire) begin
      out_label_r <= res;
      out_oor_r   <= oor;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_label         = out_label_r;
  assign out_out_of_labels = out_oor_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    memo_busy |-> !in_ready)
    else $error("request accepted during memo clear");

  a_counter_below_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, last_allocated_r} < RESERVED_LBL || last_allocated_r == '0)
    else $error("label counter reached reserved label");

  a_counter_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_fire |=> $stable(last_allocated_r))
    else $error("label counter moved outside update cycle");

  a_oor_zero_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_label_r == '0))
    else $error("out of labels with nonzero label");

endmodule

[tb/sv/tb_taint_label_union_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_taint_label_union_engine
// self-checking testbench for the taint label union engine
// ----------------------------------------------------------------------------
// Drives create and combine requests over the valid/ready input channel and
// predicts every result with a shadow copy of the label counter, the parent
// stores and the pair memo. A short directed sequence covers untainted and
// equal operands, memo hits and parent reuse. Random traffic then mixes
// combines of live labels, repeats of memoized pairs and parent/child pairs
// until labels run out and allocation starts to fail. Both sides stall at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_taint_label_union_engine;
  import tlue_pkg::*;

  localparam int LABEL_COUNT = 256;
  localparam int RESERVED    = (LABEL_COUNT > 256) ? 255 : LABEL_COUNT - 1;
  localparam int PHASE_ITEMS = 330;
  localparam int HOLD_AT     = 800;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN       = 20;

  typedef struct packed {
    lbl_t label;
    logic oom;
  } label_result_t;

  class label_union_tracker;
    int            last_alloc;
    lbl_t          par_lo [256];
    lbl_t          par_hi [256];
    lbl_t          memo [MEMO_DEPTH];
    memo_addr_t    memo_keys [$];
    lbl_t          joined [$];
    label_result_t pending [$];
    int            errors;

    function new();
      last_alloc = 0;
      errors     = 0;
      foreach (memo[i]) memo[i] = '0;
      foreach (par_lo[i]) begin
        par_lo[i] = '0;
        par_hi[i] = '0;
      end
    endfunction

    function bit grab_label(lbl_t p0, lbl_t p1, output lbl_t got);
      int next;
      next = last_alloc + 1;
      got  = '0;
      if (next >= RESERVED || next > 255) return 1'b0;
      last_alloc   = next;
      par_lo[next] = p0;
      par_hi[next] = p1;
      got          = lbl_t'(next);
      if (p0 != 0) joined.push_back(got);
      return 1'b1;
    endfunction

    function void note_request(logic op, lbl_t a, lbl_t b);
      lbl_t          lo, hi, res;
      memo_addr_t    idx;
      bit            ok;
      label_result_t want;
      ok  = 1'b1;
      res = '0;
      if (op == OP_CREATE) begin
        ok = grab_label('0, '0, res);
      end else if (a == b) begin
        res = a;
      end else if (a == 0) begin
        res = b;
      end else if (b == 0) begin
        res = a;
      end else begin
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        idx = {lo, hi};
        if (memo[idx] != 0) begin
          res = memo[idx];
        end else begin
          if (par_lo[hi] == lo || par_hi[hi] == lo) res = hi;
          else ok = grab_label(lo, hi, res);
          if (ok) begin
            memo[idx] = res;
            memo_keys.push_back(idx);
          end
        end
      end
      if (!ok) res = '0;
      want.label = res;
      want.oom   = !ok;
      pending.push_back(want);
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_result(lbl_t got_label, logic got_oom);
      label_result_t want;
      if (pending.size() == 0) begin
        log_error($sformatf("unexpected result label=%0d out_of_labels=%0b",
                            got_label, got_oom));
        return;
      end
      want = pending.pop_front();
      if (want.label !== got_label)
        log_error($sformatf("label mismatch: expected %0d, got %0d", want.label, got_label));
      if (want.oom !== got_oom)
        log_error($sformatf("out_of_labels mismatch: expected %0b, got %0b",
                            want.oom, got_oom));
    endfunction
  endclass

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic in_valid    = 1'b0;
  logic in_op       = OP_CREATE;
  lbl_t in_label_a  = '0;
  lbl_t in_label_b  = '0;
  logic out_ready   = 1'b0;
  logic in_ready;
  logic out_valid;
  lbl_t out_label;
  logic out_out_of_labels;

  label_union_tracker sb;
  int send_idle_pct = 14;
  int recv_idle_pct = 81;
  int results_seen  = 0;
  bit hold_done     = 1'b0;

  taint_label_union_engine #(
    .LABEL_COUNT(LABEL_COUNT)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_label_a       (in_label_a),
    .in_label_b       (in_label_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_label        (out_label),
    .out_out_of_labels(out_out_of_labels)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_label, out_out_of_labels);
      results_seen++;
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(logic op, lbl_t a, lbl_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_label_a <= a;
    in_label_b <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, a, b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic pick_request(output logic op, output lbl_t a, output lbl_t b);
    int         r, top;
    lbl_t       hi;
    memo_addr_t idx;
    r   = $urandom_range(0, 99);
    top = sb.last_alloc;
    a   = lbl_t'($urandom_range(0, 255));
    b   = lbl_t'($urandom_range(0, 255));
    op  = OP_COMBINE;
    if (r < 22) begin
      op = OP_CREATE;
    end else if (r < 32 || top < 2) begin
      // untainted or equal operands
      if ($urandom_range(0, 1)) b = a;
      else if ($urandom_range(0, 1)) a = '0;
      else b = '0;
    end else if (r < 55 && sb.memo_keys.size() > 0) begin
      idx = sb.memo_keys[$urandom_range(0, sb.memo_keys.size() - 1)];
      {a, b} = idx;
    end else if (r < 75 && sb.joined.size() > 0) begin
      hi = sb.joined[$urandom_range(0, sb.joined.size() - 1)];
      a  = hi;
      b  = $urandom_range(0, 1) ? sb.par_lo[hi] : sb.par_hi[hi];
    end else begin
      a = lbl_t'($urandom_range(1, top));
      b = lbl_t'($urandom_range(1, top));
    end
    if (op == OP_COMBINE && $urandom_range(0, 1)) {a, b} = {b, a};
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic op;
    lbl_t a, b;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests
    send_req(OP_COMBINE, 8'd0, 8'd0);
    send_req(OP_COMBINE, 8'd255, 8'd255);
    send_req(OP_COMBINE, 8'd0, 8'd255);
    send_req(OP_COMBINE, 8'd170, 8'd0);
    send_req(OP_COMBINE, 8'd85, 8'd85);
    send_req(OP_CREATE, 8'd0, 8'd0);
    send_req(OP_CREATE, 8'd255, 8'd255);
    send_req(OP_CREATE, 8'd170, 8'd85);
    send_req(OP_COMBINE, 8'd1, 8'd2);
    send_req(OP_COMBINE, 8'd2, 8'd1);
    send_req(OP_COMBINE, 8'd4, 8'd1);
    send_req(OP_COMBINE, 8'd2, 8'd4);
    send_req(OP_COMBINE, 8'd3, 8'd4);
    send_req(OP_COMBINE, 8'd1, 8'd1);
    send_req(OP_COMBINE, 8'd5, 8'd3);
    send_req(OP_COMBINE, 8'd4, 8'd5);
    send_req(OP_COMBINE, 8'd5, 8'd0);
    send_req(OP_CREATE, 8'd0, 8'd0);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 14 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_drained();
        pick_request(op, a, b);
        send_req(op, a, b);
      end
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
